// ===== rtl/forth_number_token_parser_defines.svh =====
// Assertion macros for the number token parser checker.
// Used by fntp_checker only; needs nothing else.
`ifndef FORTH_NUMBER_TOKEN_PARSER_DEFINES_SVH
`define FORTH_NUMBER_TOKEN_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FNTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fntp_pkg.sv =====
// Shared types and constants for the number token parser.
// No dependencies.
`timescale 1ns / 1ps

package fntp_pkg;

    localparam int OUT_W  = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int RADIX_W = 5;
    localparam int IDX_W  = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_DEFAULT_RADIX = 1'b0;

    localparam logic [RADIX_W-1:0] RADIX_RST       = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_DEC       = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX       = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_BIN       = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_LETTER_MIN = 5'd10;

    localparam logic [IDX_W-1:0] IDX_FIRST     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_QUOTED    = 3'd1;
    localparam logic [IDX_W-1:0] IDX_LIT_CLOSE = 3'd2;
    localparam logic [IDX_W-1:0] IDX_MAX       = 3'd7;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] HEX_UP_OFS = 8'h37;
    localparam logic [7:0] HEX_LO_OFS = 8'h57;

    typedef enum logic [3:0] {
        PS_HASH    = 4'b0001,
        PS_DOLLAR  = 4'b0010,
        PS_PERCENT = 4'b0100,
        PS_BODY    = 4'b1000
    } t_prefix_stage;

    typedef struct packed {
        logic             is_number;
        logic [OUT_W-1:0] number_value;
    } t_result;

endpackage

// ===== rtl/fntp_token_core.sv =====
// Per-character token state and the result logic for the number token parser.
// Depends on fntp_pkg.
`timescale 1ns / 1ps

module fntp_token_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [7:0]                   i_char,
    input  logic                         i_last,
    input  logic [fntp_pkg::RADIX_W-1:0] i_cfg_radix,
    output fntp_pkg::t_result            o_result
);
    import fntp_pkg::*;

    logic [IDX_W-1:0]       r_idx,   n_idx;
    t_prefix_stage          r_ps,    n_ps;
    logic [RADIX_W-1:0]     r_radix, n_radix;
    logic                   r_bin,   n_bin;
    logic                   r_neg,   n_neg;
    logic [VALUE_WIDTH-1:0] r_acc,   n_acc;
    logic                   r_bad,   n_bad;
    logic                   r_dig,   n_dig;
    logic [7:0]             r_quo,   n_quo;
    logic                   r_lit,   n_lit;

    // Values of the current token after taking this character.
    t_prefix_stage          c_ps;
    logic [RADIX_W-1:0]     c_radix;
    logic                   c_bin;
    logic                   c_neg;
    logic [VALUE_WIDTH-1:0] c_acc;
    logic                   c_bad;
    logic                   c_dig;
    logic [VALUE_WIDTH-1:0] c_val;
    logic                   c_lit_hit;

    always_comb begin
        logic                     taken;
        logic [7:0]               top;
        logic [7:0]               diff;
        logic [3:0]               dval;
        logic                     dok;
        logic [VALUE_WIDTH+RADIX_W-1:0] prod;

        taken   = 1'b0;
        c_ps    = r_ps;
        c_radix = (r_idx == IDX_FIRST) ? i_cfg_radix : r_radix;
        c_bin   = r_bin;
        c_neg   = r_neg;
        c_acc   = r_acc;
        c_bad   = r_bad;
        c_dig   = r_dig;
        dval    = 4'd0;
        dok     = 1'b0;
        diff    = 8'd0;
        prod    = '0;

        // A character that is not a prefix falls through every stage at once.
        if (c_ps == PS_HASH) begin
            c_ps = PS_DOLLAR;
            if (i_char == CH_HASH) begin
                c_radix = RADIX_DEC;
                taken   = 1'b1;
            end
        end
        if (!taken && c_ps == PS_DOLLAR) begin
            c_ps = PS_PERCENT;
            if (i_char == CH_DOLLAR) begin
                c_radix = RADIX_HEX;
                taken   = 1'b1;
            end
        end
        if (!taken && c_ps == PS_PERCENT) begin
            c_ps = PS_BODY;
            if (i_char == CH_PERCENT) begin
                c_radix = RADIX_BIN;
                c_bin   = 1'b1;
                taken   = 1'b1;
            end
        end
        if (!taken && !r_dig && !r_neg && !r_bad && i_char == CH_MINUS
                && c_radix == RADIX_DEC) begin
            c_neg = 1'b1;
            taken = 1'b1;
        end

        top = c_bin ? CH_1 : CH_9;
        if (i_char >= CH_0 && i_char <= top) begin
            diff = i_char - CH_0;
            dok  = 1'b1;
        end else if (c_radix >= RADIX_LETTER_MIN && i_char >= CH_UA && i_char <= CH_UF) begin
            diff = i_char - HEX_UP_OFS;
            dok  = 1'b1;
        end else if (c_radix >= RADIX_LETTER_MIN && i_char >= CH_LA && i_char <= CH_LF) begin
            diff = i_char - HEX_LO_OFS;
            dok  = 1'b1;
        end
        dval = diff[3:0];

        prod = (VALUE_WIDTH+RADIX_W)'(r_acc) * (VALUE_WIDTH+RADIX_W)'(c_radix);
        if (!taken) begin
            if (dok) begin
                c_acc = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dval);
                c_dig = 1'b1;
            end else begin
                c_bad = 1'b1;
            end
        end

        c_val     = c_neg ? ('0 - c_acc) : c_acc;
        c_lit_hit = r_lit && (r_idx == IDX_LIT_CLOSE) && (i_char == CH_QUOTE);
    end

    always_comb begin
        if (c_lit_hit) begin
            o_result.is_number    = 1'b1;
            o_result.number_value = OUT_W'(r_quo);
        end else if (!c_bad && c_dig) begin
            o_result.is_number    = 1'b1;
            o_result.number_value = OUT_W'(c_val);
        end else begin
            o_result.is_number    = 1'b0;
            o_result.number_value = '0;
        end
    end

    always_comb begin
        n_idx   = r_idx;
        n_ps    = r_ps;
        n_radix = r_radix;
        n_bin   = r_bin;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_bad   = r_bad;
        n_dig   = r_dig;
        n_quo   = r_quo;
        n_lit   = r_lit;
        if (i_en) begin
            if (i_last) begin
                n_idx   = IDX_FIRST;
                n_ps    = PS_HASH;
                n_radix = '0;
                n_bin   = 1'b0;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_bad   = 1'b0;
                n_dig   = 1'b0;
                n_quo   = 8'd0;
                n_lit   = 1'b0;
            end else begin
                n_idx   = (r_idx == IDX_MAX) ? IDX_MAX : r_idx + IDX_W'(1);
                n_ps    = c_ps;
                n_radix = c_radix;
                n_bin   = c_bin;
                n_neg   = c_neg;
                n_acc   = c_acc;
                n_bad   = c_bad;
                n_dig   = c_dig;
                if (r_idx == IDX_FIRST) begin
                    n_lit = (i_char == CH_QUOTE);
                end
                if (r_idx == IDX_QUOTED) begin
                    n_quo = i_char;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_FIRST;
            r_ps    <= PS_HASH;
            r_radix <= '0;
            r_bin   <= 1'b0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_bad   <= 1'b0;
            r_dig   <= 1'b0;
            r_quo   <= 8'd0;
            r_lit   <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_ps    <= n_ps;
            r_radix <= n_radix;
            r_bin   <= n_bin;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_bad   <= n_bad;
            r_dig   <= n_dig;
            r_quo   <= n_quo;
            r_lit   <= n_lit;
        end
    end

endmodule

// ===== rtl/fntp_cfg_regs.sv =====
// APB register file holding the default radix of the number token parser.
// Depends on fntp_pkg.
`timescale 1ns / 1ps

module fntp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fntp_pkg::ADDR_W-1:0]  paddr,
    input  logic [fntp_pkg::DATA_W-1:0]  pwdata,
    output logic [fntp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [fntp_pkg::RADIX_W-1:0] o_default_radix
);
    import fntp_pkg::*;

    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_DEFAULT_RADIX);

    always_comb begin
        n_radix = r_radix;
        if (wr_hit) begin
            n_radix = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
        end else begin
            r_radix <= n_radix;
        end
    end

    assign prdata = (paddr[2] == REG_DEFAULT_RADIX) ? DATA_W'(r_radix) : '0;
    assign o_default_radix = r_radix;

endmodule

// ===== rtl/forth_number_token_parser.sv =====
// Number token parser: one character item in per cycle, one result item per token.
// The last character of a token passes the input register, then its result is held in the output register.
// Throughput: 1 item per cycle; the input stalls only while the held character
// is a last character and the output register holds a result that is stalled.
// Reset (i_rst_n low, synchronous) empties both stages, clears the token state
// and sets the default radix to 10.
`timescale 1ns / 1ps

module forth_number_token_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fntp_pkg::ADDR_W-1:0]  paddr,
    input  logic [fntp_pkg::DATA_W-1:0]  pwdata,
    output logic [fntp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_last_char,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_is_number,
    output logic [fntp_pkg::OUT_W-1:0]   o_number_value
);
    import fntp_pkg::*;

    logic               r_s1_vld, n_s1_vld;
    logic [7:0]         r_s1_char;
    logic               r_s1_last;
    logic               r_out_vld, n_out_vld;
    t_result            r_out_res;
    t_result            core_res;
    logic [RADIX_W-1:0] cfg_radix;
    logic               in_acc;
    logic               out_free;
    logic               advance;

    fntp_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_default_radix (cfg_radix)
    );

    fntp_token_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_char      (r_s1_char),
        .i_last      (r_s1_last),
        .i_cfg_radix (cfg_radix),
        .o_result    (core_res)
    );

    // A character that ends no token never needs the output register.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_s1_vld && (!r_s1_last || out_free);
    assign o_in_stall = r_s1_vld && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_acc) begin
            n_s1_vld = 1'b1;
        end else if (advance) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (advance && r_s1_last) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_char <= i_char_code;
            r_s1_last <= i_last_char;
        end
        if (advance && r_s1_last) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_is_number    = r_out_res.is_number;
    assign o_number_value = r_out_res.number_value;

endmodule

// ===== rtl/fntp_checker.sv =====
// Port-level checks for the number token parser, bound to the top level.
// Depends on fntp_pkg and forth_number_token_parser_defines.svh.
`timescale 1ns / 1ps
`include "forth_number_token_parser_defines.svh"

module fntp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_is_number,
    input logic [fntp_pkg::OUT_W-1:0]   o_number_value
);
    import fntp_pkg::*;

    // A stalled result item keeps its valid and payload.
    `FNTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_is_number) && $stable(o_number_value), "stalled result item changed")

    // A token that is not a number reports a zero value.
    `FNTP_ASSERT_NOW(a_zero_value, i_clk, i_rst_n, o_out_valid && !o_is_number, o_number_value == '0, "non-number item carries a value")

    // The input only backs up behind a stalled result.
    `FNTP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a waiting result")

    // Nothing is offered right after reset.
    `FNTP_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && !o_in_stall, "block not empty after reset")

endmodule

bind forth_number_token_parser fntp_checker u_fntp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_is_number    (o_is_number),
    .o_number_value (o_number_value)
);

// ===== test/tb_forth_number_token_parser.sv =====
// Self-checking testbench for the Forth number token parser: it predicts each
// token result, scores the result items and varies the radix register over APB.
// Depends on fntp_pkg and forth_number_token_parser.
`timescale 1ns / 1ps

module tb_forth_number_token_parser;
    import fntp_pkg::*;

    localparam int ITEMS_TARGET = 1350;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 6;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_char_code;
    logic                i_last_char;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_is_number;
    logic [OUT_W-1:0]    o_number_value;

    // Model of the parser state, updated as each character item is accepted.
    logic [RADIX_W-1:0]  cfg_radix;
    logic [IDX_W-1:0]    tok_index;
    t_prefix_stage       tok_prefix;
    logic [RADIX_W-1:0]  tok_radix;
    bit                  tok_bin_only;
    bit                  tok_negative;
    bit                  tok_bad;
    bit                  tok_has_digit;
    bit                  tok_literal_ok;
    logic [OUT_W-1:0]    tok_acc;
    logic [7:0]          tok_quoted;

    t_result             expected_numbers[$];
    logic [7:0]          token_chars[$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  burst_left = 0;
    bit                  gaps_on = 1'b0;
    t_stall_mode         stall_mode = STALL_NONE;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  hold_left = 0;

    forth_number_token_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_number    (o_is_number),
        .o_number_value (o_number_value)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic clear_token_state();
        tok_index      = IDX_FIRST;
        tok_prefix     = PS_HASH;
        tok_radix      = '0;
        tok_bin_only   = 1'b0;
        tok_negative   = 1'b0;
        tok_bad        = 1'b0;
        tok_has_digit  = 1'b0;
        tok_literal_ok = 1'b0;
        tok_acc        = '0;
        tok_quoted     = 8'h00;
    endtask

    // Advances the model by one character and queues the token result on the last one.
    task automatic predict_parse(input logic [7:0] c, input logic last);
        int         digit;
        bit         taken;
        logic [7:0] top;
        t_result    res;
        taken = 1'b0;
        if (tok_index == IDX_FIRST) begin
            tok_radix      = cfg_radix;
            tok_literal_ok = (c == CH_QUOTE);
        end else if (tok_index == IDX_QUOTED) begin
            tok_quoted = c;
        end
        // Each prefix stage is passed once, so the prefixes only count in order.
        if (tok_prefix == PS_HASH) begin
            tok_prefix = PS_DOLLAR;
            if (c == CH_HASH) begin
                tok_radix = RADIX_DEC;
                taken = 1'b1;
            end
        end
        if (!taken && tok_prefix == PS_DOLLAR) begin
            tok_prefix = PS_PERCENT;
            if (c == CH_DOLLAR) begin
                tok_radix = RADIX_HEX;
                taken = 1'b1;
            end
        end
        if (!taken && tok_prefix == PS_PERCENT) begin
            tok_prefix = PS_BODY;
            if (c == CH_PERCENT) begin
                tok_radix = RADIX_BIN;
                tok_bin_only = 1'b1;
                taken = 1'b1;
            end
        end
        if (!taken && !tok_has_digit && !tok_negative && !tok_bad && c == CH_MINUS &&
            tok_radix == RADIX_DEC) begin
            tok_negative = 1'b1;
            taken = 1'b1;
        end
        if (!taken) begin
            digit = -1;
            top = tok_bin_only ? CH_1 : CH_9;
            if (c >= CH_0 && c <= top) digit = int'(c) - int'(CH_0);
            if (tok_radix >= RADIX_LETTER_MIN && c >= CH_UA && c <= CH_UF) begin
                digit = int'(c) - int'(CH_UA) + 10;
            end
            if (tok_radix >= RADIX_LETTER_MIN && c >= CH_LA && c <= CH_LF) begin
                digit = int'(c) - int'(CH_LA) + 10;
            end
            if (digit < 0) begin
                tok_bad = 1'b1;
            end else begin
                tok_acc = tok_acc * {{(OUT_W-RADIX_W){1'b0}}, tok_radix} + OUT_W'(digit);
                tok_has_digit = 1'b1;
            end
        end
        if (!last) begin
            if (tok_index != IDX_MAX) tok_index++;
        end else begin
            res.is_number = 1'b0;
            res.number_value = '0;
            if (tok_literal_ok && tok_index == IDX_LIT_CLOSE && c == CH_QUOTE) begin
                res.is_number = 1'b1;
                res.number_value = {{(OUT_W-8){1'b0}}, tok_quoted};
            end else if (!tok_bad && tok_has_digit) begin
                res.is_number = 1'b1;
                res.number_value = tok_negative ? -tok_acc : tok_acc;
            end
            expected_numbers.push_back(res);
            clear_token_state();
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_parse(c, last);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_token();
        for (int i = 0; i < token_chars.size(); i++) begin
            send_char(token_chars[i], i == token_chars.size() - 1);
        end
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) != 0) ? CH_UA + 8'(v - 10) : CH_LA + 8'(v - 10);
    endfunction

    // Mostly well-formed numbers and literals, then broken tokens and raw noise.
    task automatic build_token();
        int                 kind;
        int                 n;
        int                 pos;
        logic [RADIX_W-1:0] r;
        bit                 bin;
        token_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            token_chars.push_back(CH_QUOTE);
            token_chars.push_back(8'($urandom_range(0, 255)));
            if (kind < 2) begin
                token_chars.push_back(CH_QUOTE);
                token_chars.push_back(8'($urandom_range(0, 255)));
            end else if (kind >= 4) begin
                token_chars.push_back(CH_QUOTE);
            end
        end else if (kind >= 85) begin
            repeat ($urandom_range(1, 7)) token_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            r = cfg_radix;
            bin = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                token_chars.push_back(CH_HASH);
                r = RADIX_DEC;
            end
            if ($urandom_range(0, 3) == 0) begin
                token_chars.push_back(CH_DOLLAR);
                r = RADIX_HEX;
            end
            if ($urandom_range(0, 4) == 0) begin
                token_chars.push_back(CH_PERCENT);
                r = RADIX_BIN;
                bin = 1'b1;
            end
            if (r == RADIX_DEC && $urandom_range(0, 2) == 0) token_chars.push_back(CH_MINUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            if (kind >= 78) n = 0;
            repeat (n) begin
                if (bin) token_chars.push_back(digit_char($urandom_range(0, 1)));
                else if (r >= RADIX_LETTER_MIN) token_chars.push_back(digit_char($urandom_range(0, 15)));
                else token_chars.push_back(digit_char($urandom_range(0, 9)));
            end
            if (token_chars.size() == 0) token_chars.push_back(CH_HASH);
            if (kind >= 70 && kind < 78) begin
                pos = $urandom_range(0, token_chars.size() - 1);
                case ($urandom_range(0, 5))
                    0: token_chars[pos] = CH_HASH;
                    1: token_chars[pos] = CH_DOLLAR;
                    2: token_chars[pos] = CH_PERCENT;
                    3: token_chars[pos] = CH_MINUS;
                    4: token_chars[pos] = CH_QUOTE;
                    default: token_chars[pos] = 8'($urandom_range(0, 255));
                endcase
            end
        end
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_default_radix(input logic [RADIX_W-1:0] radix);
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEFAULT_RADIX, 2'b00};
        pwdata  <= {{(DATA_W-RADIX_W){1'b0}}, radix};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_radix = radix;
    endtask

    task automatic run_random_tokens(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            build_token();
            send_token();
        end
    endtask

    // Reset radix, literals, prefixes, signs, digitless tokens and byte extremes.
    task automatic test_directed_tokens();
        gaps_on = 1'b0;
        stall_mode = STALL_NONE;
        send_char(CH_QUOTE, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_QUOTE, 1'b1);
        send_char(8'h00, 1'b1);
        send_text("#-");
        send_text("$fF");
        send_text("%12");
        send_text("-9");
        send_text("3-");
        send_text("#$%10");
        send_text("--1");
    endtask

    task automatic test_radix_extremes();
        gaps_on = 1'b1;
        stall_mode = STALL_LIGHT;
        set_default_radix(RADIX_BIN);
        run_random_tokens(120);
        set_default_radix(RADIX_HEX);
        run_random_tokens(120);
    endtask

    task automatic test_output_backpressure();
        drain_block();
        gaps_on = 1'b0;
        stall_mode = STALL_NONE;
        hold_requests++;
        repeat (25) send_text("7");
        repeat (10) send_text("12");
        stall_mode = STALL_HEAVY;
        gaps_on = 1'b1;
        run_random_tokens(40);
    endtask

    task automatic test_random_tokens();
        while (items_sent < ITEMS_TARGET - 120) begin
            set_default_radix(RADIX_W'($urandom_range(2, 16)));
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            run_random_tokens($urandom_range(100, 200));
        end
    endtask

    // Receiver stall pattern; a long hold-off is requested by bumping hold_requests.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 25);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
                default:     i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_numbers.size() == 0) begin
                report_mismatch("result item with no token pending");
            end else begin
                want = expected_numbers.pop_front();
                if (o_is_number !== want.is_number) begin
                    report_mismatch($sformatf("is_number %b, wanted %b",
                                              o_is_number, want.is_number));
                end
                if (o_number_value !== want.number_value) begin
                    report_mismatch($sformatf("number_value %h, wanted %h",
                                              o_number_value, want.number_value));
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = 8'h00;
        i_last_char = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg_radix   = RADIX_RST;
        clear_token_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_tokens();
        test_radix_extremes();
        test_random_tokens();
        test_output_backpressure();
        drain_block();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fntp_pkg.sv
rtl/fntp_token_core.sv
rtl/fntp_cfg_regs.sv
rtl/forth_number_token_parser.sv
rtl/fntp_checker.sv
test/tb_forth_number_token_parser.sv
